// ===== src/dq_pkg.sv =====
// Shared constants and types for the double-ended queue.
// No dependencies; used by dq_cell and double_ended_queue_top.
`default_nettype none

package dq_pkg;

    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 32;

    // widths of the item fields
    localparam int OP_W      = 3;
    localparam int PORT_VAL_W = 32;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 5;

    // internal entry count, wide enough to hold DEPTH itself
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd1;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_REMOVE     = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    // per-cycle command broadcast to every cell, already qualified
    // by accept and by the full/empty checks
    typedef struct packed {
        logic push_back;
        logic push_front;
        logic pop_front;
        logic remove;
    } cell_cmd_t;

endpackage

`default_nettype wire

// ===== src/double_ended_queue_top.sv =====
// Double-ended queue: a row of dq_cell entries plus count and result register.
// Depends on dq_pkg and dq_cell.
// Takes one item per clock and gives its result in the next cycle: every
// operation (push or pop at either end, remove of the first equal entry) is
// done in a single pass across the cell row, where all cells compare and shift
// at once. The result sits in an output register; a new item is taken while
// that register is empty or being read in the same cycle.
`default_nettype none

module double_ended_queue_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [dq_pkg::OP_W-1:0]         s_operation,
    input  wire logic [dq_pkg::PORT_VAL_W-1:0]   s_value,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [dq_pkg::PORT_VAL_W-1:0]        m_out_value,
    output logic [dq_pkg::STATUS_W-1:0]          m_status,
    output logic [dq_pkg::COUNT_W-1:0]           m_count
);

    localparam int D = dq_pkg::DEPTH;
    localparam int W = dq_pkg::VALUE_WIDTH;

    logic                           accept;
    logic [dq_pkg::CNT_W-1:0]       count_reg;
    logic [dq_pkg::CNT_W-1:0]       count_next;
    logic                           m_valid_reg;
    logic [dq_pkg::PORT_VAL_W-1:0]  m_out_value_reg;
    logic [dq_pkg::PORT_VAL_W-1:0]  m_out_value_next;
    logic [dq_pkg::STATUS_W-1:0]    m_status_reg;
    logic [dq_pkg::STATUS_W-1:0]    m_status_next;

    logic                           full;
    logic                           empty;
    logic [W-1:0]                   key;
    dq_pkg::cell_cmd_t              cmd;

    logic [D+1:0]                   occ;      // occ[i+1] is cell i
    logic [D:0]                     hit;
    logic [W-1:0]                   tail [D+1];
    logic [W-1:0]                   cell_data [D];

    // no item is taken while in reset
    assign s_ready = aresetn && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == dq_pkg::CNT_W'(D));
    assign empty   = (count_reg == '0);
    assign key     = W'(s_value);

    always_comb begin
        cmd            = '0;
        cmd.push_back  = accept && (s_operation == dq_pkg::OP_PUSH_BACK) && !full;
        cmd.push_front = accept && (s_operation == dq_pkg::OP_PUSH_FRONT) && !full;
        cmd.pop_front  = accept && (s_operation == dq_pkg::OP_POP_FRONT) && !empty;
        cmd.remove     = accept && (s_operation == dq_pkg::OP_REMOVE);
    end

    // occupancy: cell i holds an entry when i < count
    assign occ[0]   = 1'b1;
    assign occ[D+1] = 1'b0;
    assign hit[0]   = 1'b0;
    assign tail[0]  = '0;

    genvar gi;
    generate
        for (gi = 0; gi < D; gi++) begin : g_cell
            assign occ[gi+1] = (count_reg > dq_pkg::CNT_W'(gi));

            dq_cell u_cell (
                .aclk       (aclk),
                .cmd        (cmd),
                .key        (key),
                .left_data  ((gi == 0) ? key : cell_data[(gi == 0) ? 0 : gi-1]),
                .right_data ((gi == D-1) ? key : cell_data[(gi == D-1) ? gi : gi+1]),
                .occ_left   (occ[gi]),
                .occ_here   (occ[gi+1]),
                .occ_right  (occ[gi+2]),
                .hit_in     (hit[gi]),
                .tail_in    (tail[gi]),
                .data       (cell_data[gi]),
                .hit_out    (hit[gi+1]),
                .tail_out   (tail[gi+1])
            );
        end
    endgenerate

    always_comb begin
        count_next       = count_reg;
        m_status_next    = dq_pkg::ST_OK;
        m_out_value_next = '0;
        unique case (s_operation)
            dq_pkg::OP_PUSH_BACK, dq_pkg::OP_PUSH_FRONT: begin
                if (full) begin
                    m_status_next = dq_pkg::ST_FULL;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
            dq_pkg::OP_POP_BACK: begin
                if (empty) begin
                    m_status_next = dq_pkg::ST_EMPTY;
                end else begin
                    count_next       = count_reg - 1'b1;
                    m_out_value_next = dq_pkg::PORT_VAL_W'(tail[D]);
                end
            end
            dq_pkg::OP_POP_FRONT: begin
                if (empty) begin
                    m_status_next = dq_pkg::ST_EMPTY;
                end else begin
                    count_next       = count_reg - 1'b1;
                    m_out_value_next = dq_pkg::PORT_VAL_W'(cell_data[0]);
                end
            end
            dq_pkg::OP_REMOVE: begin
                if (hit[D]) begin
                    count_next = count_reg - 1'b1;
                end else begin
                    m_status_next = dq_pkg::ST_NOT_FOUND;
                end
            end
            default: begin
                // unused codes leave the count and the entries as is
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_out_value_reg <= m_out_value_next;
            m_status_reg    <= m_status_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_value = m_out_value_reg;
    assign m_status    = m_status_reg;
    assign m_count     = dq_pkg::COUNT_W'(count_reg);

    // count stays within the row
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= dq_pkg::CNT_W'(D))
        else $error("entry count above depth");

    // reported count follows the stored count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_count == dq_pkg::COUNT_W'(count_reg)))
        else $error("result count differs from stored count");

    // refused or failed operations leave the count unchanged
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (m_status_next != dq_pkg::ST_OK) |=> $stable(count_reg))
        else $error("count changed on refused item");

    // a pop that succeeds lowers the count by one
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !empty && ((s_operation == dq_pkg::OP_POP_BACK) ||
                             (s_operation == dq_pkg::OP_POP_FRONT))
        |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop did not lower count");

endmodule

`default_nettype wire

// ===== src/dq_cell.sv =====
// One storage cell of the queue row: holds one entry, compares it with the
// search key and shifts with its neighbors. Depends on dq_pkg.
`default_nettype none

module dq_cell (
    input  wire logic                           aclk,
    input  wire dq_pkg::cell_cmd_t              cmd,
    input  wire logic [dq_pkg::VALUE_WIDTH-1:0] key,
    input  wire logic [dq_pkg::VALUE_WIDTH-1:0] left_data,
    input  wire logic [dq_pkg::VALUE_WIDTH-1:0] right_data,
    input  wire logic                           occ_left,
    input  wire logic                           occ_here,
    input  wire logic                           occ_right,
    input  wire logic                           hit_in,
    input  wire logic [dq_pkg::VALUE_WIDTH-1:0] tail_in,
    output logic [dq_pkg::VALUE_WIDTH-1:0]      data,
    output logic                                hit_out,
    output logic [dq_pkg::VALUE_WIDTH-1:0]      tail_out
);

    logic [dq_pkg::VALUE_WIDTH-1:0] data_reg;
    logic [dq_pkg::VALUE_WIDTH-1:0] data_next;
    logic                           match;
    logic                           is_tail;

    assign match   = occ_here && (data_reg == key);
    assign hit_out = hit_in || match;
    assign is_tail = occ_here && !occ_right;
    // back entry travels down the OR chain
    assign tail_out = tail_in | ({dq_pkg::VALUE_WIDTH{is_tail}} & data_reg);
    assign data     = data_reg;

    always_comb begin
        data_next = data_reg;
        if (cmd.push_back) begin
            if (occ_left && !occ_here) begin
                data_next = key;
            end
        end else if (cmd.push_front) begin
            data_next = left_data;
        end else if (cmd.pop_front) begin
            data_next = right_data;
        end else if (cmd.remove && (hit_in || match)) begin
            // close the gap at and after the first match
            data_next = right_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for double_ended_queue_top: directed and random push, pop and
// remove items, with a deque predictor in a scoreboard class that checks every result.
// Depends on dq_pkg and the double_ended_queue_top RTL.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 500;

    typedef struct packed {
        logic [dq_pkg::PORT_VAL_W-1:0] out_value;
        logic [dq_pkg::STATUS_W-1:0]   status;
        logic [dq_pkg::COUNT_W-1:0]    count;
    } deque_result_t;

    class deque_scoreboard;
        logic [dq_pkg::VALUE_WIDTH-1:0] contents[$];    // front first
        deque_result_t                  expected_results[$];
        int                             failures;

        function new();
            failures = 0;
        endfunction

        function void note_item(logic [dq_pkg::OP_W-1:0] op,
                                logic [dq_pkg::PORT_VAL_W-1:0] val);
            deque_result_t                  r;
            logic [dq_pkg::VALUE_WIDTH-1:0] v;
            int                             idx;
            bit                             found;
            v = val[dq_pkg::VALUE_WIDTH-1:0];
            r.out_value = '0;
            r.status    = dq_pkg::ST_OK;
            found       = 1'b0;
            case (op)
                dq_pkg::OP_PUSH_BACK: begin
                    if (contents.size() >= dq_pkg::DEPTH) r.status = dq_pkg::ST_FULL;
                    else contents.push_back(v);
                end
                dq_pkg::OP_POP_BACK: begin
                    if (contents.size() == 0) r.status = dq_pkg::ST_EMPTY;
                    else r.out_value = dq_pkg::PORT_VAL_W'(contents.pop_back());
                end
                dq_pkg::OP_PUSH_FRONT: begin
                    if (contents.size() >= dq_pkg::DEPTH) r.status = dq_pkg::ST_FULL;
                    else contents.push_front(v);
                end
                dq_pkg::OP_POP_FRONT: begin
                    if (contents.size() == 0) r.status = dq_pkg::ST_EMPTY;
                    else r.out_value = dq_pkg::PORT_VAL_W'(contents.pop_front());
                end
                dq_pkg::OP_REMOVE: begin
                    // first match from the front goes, the rest close up
                    r.status = dq_pkg::ST_NOT_FOUND;
                    for (idx = 0; idx < contents.size() && !found; idx++) begin
                        if (contents[idx] == v) begin
                            contents.delete(idx);
                            r.status = dq_pkg::ST_OK;
                            found    = 1'b1;
                        end
                    end
                end
                default: ;  // unused codes change nothing
            endcase
            r.count = dq_pkg::COUNT_W'(contents.size());
            expected_results.push_back(r);
        endfunction

        function void check_result(logic [dq_pkg::PORT_VAL_W-1:0] ov,
                                   logic [dq_pkg::STATUS_W-1:0] st,
                                   logic [dq_pkg::COUNT_W-1:0] cnt);
            deque_result_t want;
            if (expected_results.size() == 0) begin
                if (failures < 10)
                    $display("tb: unexpected result value=%h status=%0d count=%0d",
                             ov, st, cnt);
                failures++;
                return;
            end
            want = expected_results.pop_front();
            if (ov !== want.out_value || st !== want.status || cnt !== want.count) begin
                if (failures < 10)
                    $display({"tb: mismatch exp value=%h status=%0d count=%0d,",
                              " got value=%h status=%0d count=%0d"},
                             want.out_value, want.status, want.count, ov, st, cnt);
                failures++;
            end
        endfunction

        function int waiting();
            return expected_results.size();
        endfunction
    endclass

    logic                          aclk        = 1'b0;
    logic                          aresetn     = 1'b0;
    logic                          s_valid     = 1'b0;
    logic                          s_ready;
    logic [dq_pkg::OP_W-1:0]       s_operation = '0;
    logic [dq_pkg::PORT_VAL_W-1:0] s_value     = '0;
    logic                          m_valid;
    logic                          m_ready     = 1'b0;
    logic [dq_pkg::PORT_VAL_W-1:0] m_out_value;
    logic [dq_pkg::STATUS_W-1:0]   m_status;
    logic [dq_pkg::COUNT_W-1:0]    m_count;

    deque_scoreboard sb = new();
    bit              steady = 1'b0;   // no idling on either side while set
    int              cycles = 0;
    logic [dq_pkg::PORT_VAL_W-1:0] value_pool[6];

    double_ended_queue_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_value (m_out_value),
        .m_status    (m_status),
        .m_count     (m_count)
    );

    always #5 aclk = ~aclk;

    function automatic bit take_break();
        return !steady && ($urandom_range(99) < 23);
    endfunction

    // result side: check on accept, then pick next ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_out_value, m_status, m_count);
        m_ready <= !take_break();
    end

    // called right after a rising edge; returns right after the accepting edge
    task automatic send_item(input logic [dq_pkg::OP_W-1:0] op,
                             input logic [dq_pkg::PORT_VAL_W-1:0] val);
        while (take_break()) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_value     <= val;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(op, val);
    endtask

    // mode 0 grows the store, mode 1 drains it, mode 2 is balanced
    function automatic logic [dq_pkg::OP_W-1:0] pick_op(int mode);
        int r;
        r = $urandom_range(99);
        if (r >= 98) return dq_pkg::OP_W'($urandom_range(7, 5));
        case (mode)
            0: begin
                if (r < 40) return dq_pkg::OP_PUSH_BACK;
                if (r < 80) return dq_pkg::OP_PUSH_FRONT;
                if (r < 87) return dq_pkg::OP_POP_BACK;
                if (r < 92) return dq_pkg::OP_POP_FRONT;
                return dq_pkg::OP_REMOVE;
            end
            1: begin
                if (r < 8)  return dq_pkg::OP_PUSH_BACK;
                if (r < 15) return dq_pkg::OP_PUSH_FRONT;
                if (r < 50) return dq_pkg::OP_POP_BACK;
                if (r < 85) return dq_pkg::OP_POP_FRONT;
                return dq_pkg::OP_REMOVE;
            end
            default: begin
                if (r < 20) return dq_pkg::OP_PUSH_BACK;
                if (r < 40) return dq_pkg::OP_PUSH_FRONT;
                if (r < 60) return dq_pkg::OP_POP_BACK;
                if (r < 78) return dq_pkg::OP_POP_FRONT;
                return dq_pkg::OP_REMOVE;
            end
        endcase
    endfunction

    function automatic logic [dq_pkg::PORT_VAL_W-1:0] pick_value(
        logic [dq_pkg::OP_W-1:0] op);
        int r;
        r = $urandom_range(99);
        // removes mostly aim at something that is stored
        if (op == dq_pkg::OP_REMOVE && sb.contents.size() != 0 && r < 60)
            return dq_pkg::PORT_VAL_W'(sb.contents[$urandom_range(sb.contents.size() - 1)]);
        if (r < 70) return value_pool[$urandom_range(5)];   // duplicates on purpose
        return dq_pkg::PORT_VAL_W'($urandom());
    endfunction

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("tb: FAIL");
        $finish;
    end

    initial begin : stimulus
        int                       n;
        int                       mode;
        logic [dq_pkg::OP_W-1:0]  op;
        value_pool[0] = '0;
        value_pool[1] = '1;
        for (n = 2; n < 6; n++) value_pool[n] = $urandom();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // empty store, unused codes, then a short build-up and tear-down
        send_item(dq_pkg::OP_POP_BACK, 32'h0);
        send_item(dq_pkg::OP_POP_FRONT, 32'h0);
        send_item(dq_pkg::OP_REMOVE, 32'h0);
        send_item(3'd5, 32'hDEAD_BEEF);
        send_item(3'd6, 32'h0);
        send_item(3'd7, 32'hFFFF_FFFF);
        send_item(dq_pkg::OP_PUSH_BACK, 32'h0);
        send_item(dq_pkg::OP_PUSH_BACK, 32'hFFFF_FFFF);
        send_item(dq_pkg::OP_PUSH_FRONT, 32'hA5A5_A5A5);
        send_item(dq_pkg::OP_PUSH_BACK, 32'h5A5A_5A5A);
        send_item(dq_pkg::OP_PUSH_FRONT, 32'h0);
        send_item(dq_pkg::OP_REMOVE, 32'h0);            // two zeros stored, front one goes
        send_item(dq_pkg::OP_REMOVE, 32'hFFFF_FFFF);    // match in the middle
        send_item(dq_pkg::OP_REMOVE, 32'h1234_5678);    // no match
        send_item(dq_pkg::OP_POP_BACK, 32'h0);
        send_item(dq_pkg::OP_POP_FRONT, 32'h0);
        send_item(dq_pkg::OP_POP_FRONT, 32'h0);
        send_item(dq_pkg::OP_POP_BACK, 32'h0);
        send_item(dq_pkg::OP_REMOVE, 32'hFFFF_FFFF);    // store already empty, no match

        mode = 0;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) mode = (n / 40) % 3;
            steady = (n >= 200 && n < 300);
            op = pick_op(mode);
            send_item(op, pick_value(op));
        end
        s_valid <= 1'b0;
        steady = 1'b0;

        while (sb.waiting() != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
        if (sb.failures == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule

`default_nettype wire
